/* design/mrfc_pkg.sv */
// Package with shared types, constants and the CRC-16 byte step for the frame checker.
`timescale 1ns / 1ps
package mrfc_pkg;

	// Default frame header geometry.
	localparam int HeaderLenDefault  = 3;
	localparam int CountIndexDefault = 2;

	// CRC-16 constants (reflected polynomial).
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [15:0] CrcInit = 16'hFFFF;

	// Number of trailing CRC bytes in a frame.
	localparam logic [8:0] CrcBytes = 9'd2;

	// Width of the packed result and of the output tdata.
	localparam int ResultWidth = 42;
	localparam int OutDataWidth = 48;

	// One result, packed so that crc_ok lands in the lowest bit.
	typedef struct packed {
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
		logic [8:0]  frame_length;
		logic        crc_ok;
	} mrfc_result_t;

	// Room indication from the output register to the frame core.
	typedef struct packed {
		logic free;
	} mrfc_out_ctrl_t;

	// Advance the CRC by one byte, eight shift steps unrolled.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/modbus_rtu_response_frame_checker_unit.sv */
// Path: a frame-ending byte is registered in the input stage, and its result is then
// registered in the output register, which makes the result transaction.
// Throughput: one byte per cycle; the CRC byte step is a single combinational stage.
// Only a frame-ending byte can stall, and only while the output register is held.
// Reset (arst_n low, asynchronous) empties both stages and rearms for a new frame
// with the CRC at 0xFFFF; no clearing pass is needed.
`timescale 1ns / 1ps
module modbus_rtu_response_frame_checker_unit #(
	parameter int HEADER_LEN  = mrfc_pkg::HeaderLenDefault,
	parameter int COUNT_INDEX = mrfc_pkg::CountIndexDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	// crc_ok[0], frame_length[9:1], received_crc[25:10], computed_crc[41:26], zeros
	output logic [mrfc_pkg::OutDataWidth-1:0] m_axis_tdata
);
	import mrfc_pkg::*;

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           load;
	mrfc_result_t   result;
	mrfc_out_ctrl_t out_ctrl;

	// Input register stage.
	mrfc_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1)
	);

	// Frame tracking and CRC.
	mrfc_frame_core #(
		.HEADER_LEN  (HEADER_LEN),
		.COUNT_INDEX (COUNT_INDEX)
	) u_frame_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_in   (out_ctrl),
		.advance  (advance),
		.load     (load),
		.result   (result)
	);

	// Result register.
	mrfc_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.result        (result),
		.out_ctrl      (out_ctrl),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The ok flag agrees with the two CRC fields of a shown result.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[25:10] == m_axis_tdata[41:26])))
	else $error("crc_ok does not match the CRC fields");

	// A shown frame is at least the header plus the two CRC bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[9:1] >= 9'(HEADER_LEN + 2)))
	else $error("frame_length below header plus CRC");

	// An empty input stage always accepts.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
	else $error("input stage empty but not ready");

	// A result is loaded only when the output register has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_ctrl.free)
	else $error("result loaded into a held output register");

endmodule

/* design/mrfc_in_stage.sv */
// Input register stage that holds one accepted byte until the frame core takes it.
`timescale 1ns / 1ps
module mrfc_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import mrfc_pkg::*;

	// The stage can take a new transaction when empty or when its byte moves on.
	assign s_axis_tready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

/* design/mrfc_frame_core.sv */
// Frame tracking state, running CRC and result formation for one byte per cycle, unless a frame-ending byte waits.
`timescale 1ns / 1ps
module mrfc_frame_core #(
	parameter int HEADER_LEN  = mrfc_pkg::HeaderLenDefault,
	parameter int COUNT_INDEX = mrfc_pkg::CountIndexDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  logic [7:0]             byte_s1,
	input  mrfc_pkg::mrfc_out_ctrl_t out_in,
	output logic                   advance,
	output logic                   load,
	output mrfc_pkg::mrfc_result_t result
);
	import mrfc_pkg::*;

	// The count byte falls back to the last header byte when placed outside it.
	localparam int CountPosInt = (COUNT_INDEX < HEADER_LEN) ? COUNT_INDEX : HEADER_LEN - 1;
	localparam logic [8:0] CountPos  = 9'(CountPosInt);
	localparam logic [8:0] HeaderLen = 9'(HEADER_LEN);

	logic [8:0]  byte_position_q;
	logic [7:0]  body_count_q;
	logic [15:0] running_crc_q;
	logic [7:0]  crc_low_byte_q;

	logic [7:0]  count_now;
	logic [8:0]  data_len;
	logic        in_body;
	logic        at_crc_low;
	logic        emit;
	logic [15:0] rx_crc;

	// Decode where the current byte sits in the frame.
	always_comb begin
		count_now  = (byte_position_q == CountPos) ? byte_s1 : body_count_q;
		data_len   = HeaderLen + {1'b0, count_now};
		in_body    = byte_position_q < data_len;
		at_crc_low = byte_position_q == data_len;
		emit       = !in_body && !at_crc_low;
		rx_crc     = {byte_s1, crc_low_byte_q};
	end

	// A byte that ends a frame waits for room in the output register.
	assign advance = valid_s1 && (!emit || out_in.free);
	assign load    = advance && emit;

	// Result fields for the frame that ends with this byte.
	always_comb begin
		result.crc_ok       = running_crc_q == rx_crc;
		result.frame_length = data_len + CrcBytes;
		result.received_crc = rx_crc;
		result.computed_crc = running_crc_q;
	end

	// Frame state: position, latched count, running CRC and held low CRC byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			body_count_q    <= '0;
			running_crc_q   <= CrcInit;
			crc_low_byte_q  <= '0;
		end else if (advance) begin
			if (in_body) begin
				body_count_q    <= count_now;
				running_crc_q   <= crc16_byte(running_crc_q, byte_s1);
				byte_position_q <= byte_position_q + 9'd1;
			end else if (at_crc_low) begin
				body_count_q    <= count_now;
				crc_low_byte_q  <= byte_s1;
				byte_position_q <= byte_position_q + 9'd1;
			end else begin
				byte_position_q <= '0;
				body_count_q    <= '0;
				running_crc_q   <= CrcInit;
			end
		end
	end

endmodule

/* design/mrfc_out_reg.sv */
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module mrfc_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  mrfc_pkg::mrfc_result_t   result,
	output mrfc_pkg::mrfc_out_ctrl_t out_ctrl,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// crc_ok[0], frame_length[9:1], received_crc[25:10], computed_crc[41:26], zeros
	output logic [mrfc_pkg::OutDataWidth-1:0] m_axis_tdata
);
	import mrfc_pkg::*;

	mrfc_result_t result_q;

	// The register is free when empty or when its transaction completes now.
	assign out_ctrl.free = !m_axis_tvalid || m_axis_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_ctrl.free) begin
			m_axis_tvalid <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign m_axis_tdata = {{(OutDataWidth - ResultWidth){1'b0}}, result_q};

endmodule

/* tb/tb_modbus_rtu_response_frame_checker_unit.sv */
// Self-checking testbench for the Modbus RTU response frame checker unit.
`timescale 1ns / 1ps
module tb_modbus_rtu_response_frame_checker_unit;
	import mrfc_pkg::*;

	// Frame geometry used for the instance and for the frame tracker.
	localparam int HDR_LEN = HeaderLenDefault;
	localparam int CNT_IDX = CountIndexDefault;
	localparam int COUNT_POS = (CNT_IDX < HDR_LEN) ? CNT_IDX : HDR_LEN - 1;
	localparam int RANDOM_BYTES = 440;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	// How header and body bytes are filled.
	typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_kind_t;
	// How the trailing CRC bytes are formed.
	typedef enum int {
		CRC_GOOD, CRC_FLIP_LOW, CRC_FLIP_HIGH, CRC_ALL_ZEROS, CRC_ALL_ONES
	} crc_kind_t;
	// Receiver readiness pattern for one segment.
	typedef enum int {RX_READY, RX_MOSTLY, RX_SPARSE, RX_HELD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutDataWidth-1:0] m_axis_tdata;

	// Frame tracker state, mirrors what the unit should hold.
	logic [8:0] trk_pos;
	logic [7:0] trk_count;
	logic [15:0] trk_crc;
	logic [7:0] trk_crc_lo;

	mrfc_result_t pending_results[$];
	int error_count = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	rx_mode_t rx_mode = RX_READY;
	int rx_segment_left = 0;

	modbus_rtu_response_frame_checker_unit #(
		.HEADER_LEN(HDR_LEN),
		.COUNT_INDEX(CNT_IDX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One reflected CRC-16 byte update, shifting out the low bit each step.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? CrcPoly : 16'h0000);
		return c;
	endfunction

	// Advance the frame tracker by one accepted byte and queue a result at frame end.
	task automatic track_byte(input logic [7:0] b);
		logic [8:0] data_len;
		mrfc_result_t r;
		if (trk_pos == COUNT_POS) begin
			trk_count = b;
		end
		// Summed at 9 bits so counts from 253 to 255 do not wrap.
		data_len = 9'(HDR_LEN) + {1'b0, trk_count};
		if (trk_pos < data_len) begin
			trk_crc = crc16_step(trk_crc, b);
			trk_pos = trk_pos + 9'd1;
		end else if (trk_pos == data_len) begin
			trk_crc_lo = b;
			trk_pos = trk_pos + 9'd1;
		end else begin
			r.received_crc = {b, trk_crc_lo};
			r.computed_crc = trk_crc;
			r.crc_ok = (r.received_crc == trk_crc);
			r.frame_length = data_len + CrcBytes;
			pending_results.insert(pending_results.size(), r);
			// Rearm; the low CRC byte is simply overwritten by the next frame.
			trk_pos = '0;
			trk_count = '0;
			trk_crc = CrcInit;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Send one byte, opening a new burst after a random gap when the last one ran out.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_byte(b);
	endtask

	// Build one response frame with the given body count and send it byte by byte.
	task automatic send_frame(input int count, input fill_kind_t fill, input crc_kind_t crc_kind);
		logic [7:0] frame_bytes[$];
		logic [7:0] b;
		logic [15:0] crc;
		int i;
		crc = CrcInit;
		for (i = 0; i < HDR_LEN + count; i++) begin
			case (fill)
				FILL_ZEROS: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			if (i == COUNT_POS) begin
				b = 8'(count);
			end
			crc = crc16_step(crc, b);
			frame_bytes.insert(frame_bytes.size(), b);
		end
		case (crc_kind)
			CRC_FLIP_LOW: crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
			CRC_FLIP_HIGH: crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
			CRC_ALL_ZEROS: crc = 16'h0000;
			CRC_ALL_ONES: crc = 16'hFFFF;
			default: ;
		endcase
		// CRC goes out low byte first.
		frame_bytes.insert(frame_bytes.size(), crc[7:0]);
		frame_bytes.insert(frame_bytes.size(), crc[15:8]);
		foreach (frame_bytes[k]) begin
			send_byte(frame_bytes[k]);
		end
	endtask

	// Short frames: zero count, byte extremes, each way of breaking the CRC.
	task automatic test_directed_frames();
		send_frame(0, FILL_ZEROS, CRC_GOOD);
		send_frame(0, FILL_ONES, CRC_FLIP_LOW);
		send_frame(1, FILL_ONES, CRC_GOOD);
		send_frame(2, FILL_RANDOM, CRC_FLIP_HIGH);
		send_frame(0, FILL_RANDOM, CRC_ALL_ZEROS);
		send_frame(1, FILL_ZEROS, CRC_ALL_ONES);
	endtask

	// Two of the counts whose frame length needs the ninth bit.
	task automatic test_large_counts();
		send_frame(254, FILL_RANDOM, CRC_GOOD);
		send_frame(255, FILL_RANDOM, CRC_FLIP_LOW);
	endtask

	// The sender stops until every pending result has been taken, then resumes.
	task automatic test_pause_until_drained();
		send_frame(3, FILL_RANDOM, CRC_GOOD);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		send_frame(0, FILL_RANDOM, CRC_FLIP_HIGH);
	endtask

	// Mostly well-formed frames of small size with random content, some broken ones.
	task automatic test_random_frames();
		int sent;
		int count;
		int pick;
		fill_kind_t fill;
		crc_kind_t crc_kind;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				count = $urandom_range(0, 6);
			end else if (pick < 93) begin
				count = $urandom_range(7, 40);
			end else begin
				count = $urandom_range(0, 255);
			end
			pick = $urandom_range(0, 99);
			fill = (pick < 90) ? FILL_RANDOM : (pick < 95) ? FILL_ZEROS : FILL_ONES;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				crc_kind = CRC_GOOD;
			end else begin
				crc_kind = crc_kind_t'($urandom_range(CRC_FLIP_LOW, CRC_ALL_ONES));
			end
			send_frame(count, fill, crc_kind);
			sent += HDR_LEN + count + 2;
		end
	endtask

	// Receiver readiness follows a randomly chosen pattern that changes from segment to segment.
	always @(posedge clk) begin
		if (rx_segment_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(RX_READY, RX_HELD));
			rx_segment_left = $urandom_range(20, 80);
		end else begin
			rx_segment_left--;
		end
		case (rx_mode)
			RX_READY: m_axis_tready <= 1'b1;
			RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= 1'b0;
		endcase
	end

	// Check each result transaction against the oldest pending result.
	always @(posedge clk) begin
		mrfc_result_t got;
		mrfc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = mrfc_result_t'(m_axis_tdata[ResultWidth-1:0]);
			if (m_axis_tdata[OutDataWidth-1:ResultWidth] != '0) begin
				report_mismatch("padding", 48'(m_axis_tdata[OutDataWidth-1:ResultWidth]),
					48'd0);
			end
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 48'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.crc_ok != want.crc_ok) begin
					report_mismatch("crc_ok", 48'(got.crc_ok), 48'(want.crc_ok));
				end
				if (got.frame_length != want.frame_length) begin
					report_mismatch("frame_length", 48'(got.frame_length),
						48'(want.frame_length));
				end
				if (got.received_crc != want.received_crc) begin
					report_mismatch("received_crc", 48'(got.received_crc),
						48'(want.received_crc));
				end
				if (got.computed_crc != want.computed_crc) begin
					report_mismatch("computed_crc", 48'(got.computed_crc),
						48'(want.computed_crc));
				end
			end
		end
	end

	// Watchdog: ends the run with a failure once the idle count without any transaction reaches IDLE_LIMIT.
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("tb_modbus_rtu_response_frame_checker_unit: FAIL");
		$finish;
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		trk_pos = '0;
		trk_count = '0;
		trk_crc = CrcInit;
		trk_crc_lo = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_large_counts();
		test_pause_until_drained();
		test_random_frames();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_modbus_rtu_response_frame_checker_unit: PASS");
		end else begin
			$display("tb_modbus_rtu_response_frame_checker_unit: FAIL");
		end
		$finish;
	end

endmodule
